[rtl/core/ece_pkg.sv]
// Shared constants and types for the ease curve evaluator.
`timescale 1ns / 1ps

package ece_pkg;

    localparam int FRACTION_BITS_DEFAULT = 16;

    // Intermediate and output saturation limits
    localparam logic signed [63:0] INTER_HI = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] INTER_LO = 64'shC000_0000_0000_0000;
    localparam logic signed [63:0] OUT_HI   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] OUT_LO   = 64'shFFFF_8000_0000_0000;

    // Configuration register indexes
    localparam logic [1:0] REG_CURVE_TYPE  = 2'd0;
    localparam logic [1:0] REG_START_SPEED = 2'd1;
    localparam logic [1:0] REG_GOAL_SPEED  = 2'd2;
    localparam logic [1:0] REG_EASE_LENGTH = 2'd3;

    // Curve and operation codes
    localparam logic CURVE_RAMP   = 1'b0;
    localparam logic CURVE_SPLINE = 1'b1;
    localparam logic OP_POSITION  = 1'b0;
    localparam logic OP_VELOCITY  = 1'b1;

    // Request into a fixed-point multiplier: half selects one extra right shift
    typedef struct packed {
        logic               valid;
        logic               half;
        logic signed [63:0] a;
        logic signed [63:0] b;
    } mul_req_t;

    // Saturated product with its overflow flag
    typedef struct packed {
        logic               valid;
        logic               ov;
        logic signed [63:0] p;
    } mul_rsp_t;

endpackage

[rtl/core/ece_mul.sv]
// Four-stage saturating fixed-point multiplier with a sideband tag.
`timescale 1ns / 1ps

module ece_mul #(
    parameter int SHIFT = 16,
    parameter int TAG_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  ece_pkg::mul_req_t req,
    input  logic [TAG_W-1:0]  req_tag,
    output ece_pkg::mul_rsp_t rsp,
    output logic [TAG_W-1:0]  rsp_tag
);
    import ece_pkg::*;

    localparam logic [127:0] MASK_F = (128'd1 << SHIFT) - 128'd1;
    localparam logic [127:0] MASK_H = (128'd1 << (SHIFT + 1)) - 128'd1;

    logic [3:0]       valid_reg;
    logic [3:0]       half_reg;
    logic [3:0]       neg_reg;
    logic [TAG_W-1:0] tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic [63:0]      mag_a_reg, mag_b_reg;
    logic [63:0]      p00_reg, p01_reg, p10_reg, p11_reg;
    logic [127:0]     prod_reg;
    logic [63:0]      res_reg;
    logic             ov_reg;

    logic [63:0]  mag_a_next, mag_b_next;
    logic [127:0] prod_next;
    logic [127:0] shifted;
    logic         frac;
    logic         big;
    logic         ov_next;
    logic [63:0]  res_next;

    // Stage 1: sign and magnitudes
    assign mag_a_next = req.a[63] ? (64'd0 - req.a) : req.a;
    assign mag_b_next = req.b[63] ? (64'd0 - req.b) : req.b;

    // Stage 3: sum of partial products
    assign prod_next = {64'd0, p00_reg}
                     + {32'd0, p01_reg, 32'd0}
                     + {32'd0, p10_reg, 32'd0}
                     + {p11_reg, 64'd0};

    // Stage 4: shift, floor, clamp
    always_comb begin
        shifted = half_reg[2] ? (prod_reg >> (SHIFT + 1)) : (prod_reg >> SHIFT);
        frac    = half_reg[2] ? (|(prod_reg & MASK_H)) : (|(prod_reg & MASK_F));
        big     = |shifted[127:63];
        if (!neg_reg[2]) begin
            ov_next  = big | shifted[62];
            res_next = ov_next ? INTER_HI : shifted[63:0];
        end else begin
            // magnitude rounds up when bits were dropped
            ov_next  = big | (shifted[62] & ((|shifted[61:0]) | frac));
            res_next = ov_next ? INTER_LO : (~shifted[63:0] + {63'd0, ~frac});
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= {valid_reg[2:0], req.valid};
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (ce) begin
            half_reg  <= {half_reg[2:0], req.half};
            neg_reg   <= {neg_reg[2:0], req.a[63] ^ req.b[63]};
            tag1_reg  <= req_tag;
            tag2_reg  <= tag1_reg;
            tag3_reg  <= tag2_reg;
            tag4_reg  <= tag3_reg;
            mag_a_reg <= mag_a_next;
            mag_b_reg <= mag_b_next;
            p00_reg   <= mag_a_reg[31:0] * mag_b_reg[31:0];
            p01_reg   <= mag_a_reg[31:0] * mag_b_reg[63:32];
            p10_reg   <= mag_a_reg[63:32] * mag_b_reg[31:0];
            p11_reg   <= mag_a_reg[63:32] * mag_b_reg[63:32];
            prod_reg  <= prod_next;
            res_reg   <= res_next;
            ov_reg    <= ov_next;
        end
    end

    assign rsp.valid = valid_reg[3];
    assign rsp.ov    = ov_reg;
    assign rsp.p     = res_reg;
    assign rsp_tag   = tag4_reg;

endmodule

[rtl/core/ease_curve_evaluator.sv]
// Top level: ease profile evaluator, divider pipeline and multiplier chain.
//
//  channel  | ports             | contents
//  ---------+-------------------+------------------------------------------------
//  input    | s_tvalid/s_tready | tdata: sample_time[31:0]; tuser: operation
//  result   | m_tvalid/m_tready | tdata: value[47:0]; tuser: overflow
//  config   | cfg_we            | cfg_addr selects register, cfg_wdata its value
//
// One item per cycle while the output is not held. The path runs through one restoring
// divider stage per quotient bit, five levels of four-stage multipliers, then a sum
// stage and the output register.
// aresetn is synchronous; it clears all valid bits and loads register defaults.
// A stall at the output freezes every stage at once; nothing is dropped.
`timescale 1ns / 1ps

module ease_curve_evaluator #(
    parameter int FRACTION_BITS = ece_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample_time
    input  logic [0:0]  s_tuser,   // [0] operation
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [47:0] value
    output logic [0:0]  m_tuser    // [0] overflow
);
    import ece_pkg::*;

    localparam int QW = 32 + FRACTION_BITS;

    typedef struct packed {
        logic [31:0]   t;
        logic [QW-1:0] u;
    } l1_tag_t;

    typedef struct packed {
        logic          op;
        logic [QW-1:0] u;
        logic [63:0]   sp;
        logic [63:0]   r;
        logic [1:0]    ov;
    } l2_tag_t;

    typedef struct packed {
        logic        op;
        logic [63:0] sp;
        logic [63:0] r;
        logic [63:0] m2;
        logic [2:0]  ov;
    } l3_tag_t;

    typedef struct packed {
        logic        op;
        logic [63:0] sp;
        logic [63:0] r;
        logic [63:0] m2;
        logic [63:0] m3;
        logic [4:0]  ov;
    } l4_tag_t;

    // Configuration registers
    logic        curve_type_reg;
    logic [31:0] start_speed_reg;
    logic [31:0] goal_speed_reg;
    logic [31:0] ease_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curve_type_reg  <= CURVE_RAMP;
            start_speed_reg <= 32'd0;
            goal_speed_reg  <= 32'd1 << FRACTION_BITS;
            ease_length_reg <= 32'd1 << FRACTION_BITS;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_CURVE_TYPE:  curve_type_reg  <= cfg_wdata[0];
                REG_START_SPEED: start_speed_reg <= cfg_wdata;
                REG_GOAL_SPEED:  goal_speed_reg  <= cfg_wdata;
                REG_EASE_LENGTH: ease_length_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Derived operands; the user must keep them constant while items are in flight (not enforced)
    logic [31:0]        len_eff;
    logic signed [63:0] s64;
    logic signed [63:0] delta64;
    logic signed [63:0] len64;
    logic signed [63:0] one64;

    assign len_eff = (ease_length_reg == 32'd0) ? 32'd1 : ease_length_reg;
    assign s64     = {{32{start_speed_reg[31]}}, start_speed_reg};
    assign delta64 = {{32{goal_speed_reg[31]}}, goal_speed_reg} - s64;
    assign len64   = {32'd0, len_eff};
    assign one64   = 64'sd1 <<< FRACTION_BITS;

    // Global advance: the whole pipeline moves unless the output is held
    logic ce;
    logic m_valid_reg;
    assign ce       = !m_valid_reg || m_tready;
    assign s_tready = ce;

    // Restoring divider, one quotient bit per stage: u = (t << F) / len
    logic          div_valid_reg [QW];
    logic [31:0]   div_rem_reg   [QW];
    logic [QW-1:0] div_nq_reg    [QW];
    logic          div_op_reg    [QW];
    logic [31:0]   div_t_reg     [QW];

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic          v_in;
        logic [31:0]   rem_in;
        logic [QW-1:0] nq_in;
        logic          op_in;
        logic [31:0]   t_in;
        logic [32:0]   trial;
        logic [32:0]   diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign v_in   = s_tvalid;
            assign rem_in = 32'd0;
            assign nq_in  = {s_tdata[31:0], {FRACTION_BITS{1'b0}}};
            assign op_in  = s_tuser[0];
            assign t_in   = s_tdata[31:0];
        end else begin : g_next
            assign v_in   = div_valid_reg[k-1];
            assign rem_in = div_rem_reg[k-1];
            assign nq_in  = div_nq_reg[k-1];
            assign op_in  = div_op_reg[k-1];
            assign t_in   = div_t_reg[k-1];
        end

        assign trial = {rem_in, nq_in[QW-1]};
        assign diff  = trial - {1'b0, len_eff};
        assign ge    = trial >= {1'b0, len_eff};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                div_valid_reg[k] <= 1'b0;
            end else if (ce) begin
                div_valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                div_rem_reg[k] <= ge ? diff[31:0] : trial[31:0];
                div_nq_reg[k]  <= {nq_in[QW-2:0], ge};
                div_op_reg[k]  <= op_in;
                div_t_reg[k]   <= t_in;
            end
        end
    end

    // Level 1: r = delta*u (ramp) or u2 = u*u (spline); sp = s*t
    mul_req_t  req1a, req1b;
    mul_rsp_t  rsp1a, rsp1b;
    l1_tag_t   tag1_in, tag1_out;
    logic [0:0] op1_in, op1_out;
    logic signed [63:0] u64_div;

    always_comb begin
        u64_div     = {{(64-QW){1'b0}}, div_nq_reg[QW-1]};
        req1a.valid = div_valid_reg[QW-1];
        req1a.half  = 1'b0;
        req1a.a     = (curve_type_reg == CURVE_RAMP) ? delta64 : u64_div;
        req1a.b     = u64_div;
        req1b.valid = div_valid_reg[QW-1];
        req1b.half  = 1'b0;
        req1b.a     = s64;
        req1b.b     = {32'd0, div_t_reg[QW-1]};
        tag1_in.t   = div_t_reg[QW-1];
        tag1_in.u   = div_nq_reg[QW-1];
        op1_in      = div_op_reg[QW-1];
    end

    ece_mul #(.SHIFT(FRACTION_BITS), .TAG_W($bits(l1_tag_t))) u_mul1a (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .req(req1a), .req_tag(tag1_in), .rsp(rsp1a), .rsp_tag(tag1_out)
    );

    ece_mul #(.SHIFT(FRACTION_BITS), .TAG_W(1)) u_mul1b (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .req(req1b), .req_tag(op1_in), .rsp(rsp1b), .rsp_tag(op1_out)
    );

    // Level 2: r*t/2 (ramp), u2*(3-2u) (spline velocity), u2*(2-u)/2 (spline position)
    mul_req_t req2;
    mul_rsp_t rsp2;
    l2_tag_t  tag2_in, tag2_out;
    logic signed [63:0] u64_l1;

    always_comb begin
        u64_l1       = {{(64-QW){1'b0}}, tag1_out.u};
        req2.valid   = rsp1a.valid && rsp1b.valid;
        req2.half    = (curve_type_reg == CURVE_RAMP) || (op1_out[0] == OP_POSITION);
        req2.a       = rsp1a.p;
        if (curve_type_reg == CURVE_RAMP) begin
            req2.b = {32'd0, tag1_out.t};
        end else if (op1_out[0] == OP_VELOCITY) begin
            req2.b = 64'(3) * one64 - (u64_l1 <<< 1);
        end else begin
            req2.b = 64'(2) * one64 - u64_l1;
        end
        tag2_in.op = op1_out[0];
        tag2_in.u  = tag1_out.u;
        tag2_in.sp = rsp1b.p;
        tag2_in.r  = rsp1a.p;
        tag2_in.ov = {rsp1b.ov, rsp1a.ov};
    end

    ece_mul #(.SHIFT(FRACTION_BITS), .TAG_W($bits(l2_tag_t))) u_mul2 (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .req(req2), .req_tag(tag2_in), .rsp(rsp2), .rsp_tag(tag2_out)
    );

    // Level 3: delta*w (spline velocity) or e = u*h (spline position)
    mul_req_t req3;
    mul_rsp_t rsp3;
    l3_tag_t  tag3_in, tag3_out;

    always_comb begin
        req3.valid  = rsp2.valid;
        req3.half   = 1'b0;
        req3.a      = (tag2_out.op == OP_VELOCITY) ? delta64
                                                   : {{(64-QW){1'b0}}, tag2_out.u};
        req3.b      = rsp2.p;
        tag3_in.op  = tag2_out.op;
        tag3_in.sp  = tag2_out.sp;
        tag3_in.r   = tag2_out.r;
        tag3_in.m2  = rsp2.p;
        tag3_in.ov  = {rsp2.ov, tag2_out.ov};
    end

    ece_mul #(.SHIFT(FRACTION_BITS), .TAG_W($bits(l3_tag_t))) u_mul3 (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .req(req3), .req_tag(tag3_in), .rsp(rsp3), .rsp_tag(tag3_out)
    );

    // Level 4: delta*e
    mul_req_t req4;
    mul_rsp_t rsp4;
    l4_tag_t  tag4_in, tag4_out;

    always_comb begin
        req4.valid = rsp3.valid;
        req4.half  = 1'b0;
        req4.a     = delta64;
        req4.b     = rsp3.p;
        tag4_in.op = tag3_out.op;
        tag4_in.sp = tag3_out.sp;
        tag4_in.r  = tag3_out.r;
        tag4_in.m2 = tag3_out.m2;
        tag4_in.m3 = rsp3.p;
        tag4_in.ov = {1'b0, rsp3.ov, tag3_out.ov};
    end

    ece_mul #(.SHIFT(FRACTION_BITS), .TAG_W($bits(l4_tag_t))) u_mul4 (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .req(req4), .req_tag(tag4_in), .rsp(rsp4), .rsp_tag(tag4_out)
    );

    // Level 5: d = (delta*e)*len
    mul_req_t req5;
    mul_rsp_t rsp5;
    l4_tag_t  tag5_in, tag5_out;

    always_comb begin
        req5.valid = rsp4.valid;
        req5.half  = 1'b0;
        req5.a     = rsp4.p;
        req5.b     = len64;
        tag5_in    = tag4_out;
        tag5_in.ov = {rsp4.ov, tag4_out.ov[3:0]};
    end

    ece_mul #(.SHIFT(FRACTION_BITS), .TAG_W($bits(l4_tag_t))) u_mul5 (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .req(req5), .req_tag(tag5_in), .rsp(rsp5), .rsp_tag(tag5_out)
    );

    // Final sum: pick the terms of the active curve and operation
    logic signed [63:0] sum_x, sum_y, sum_full;
    logic               sum_ov_in;
    logic               sum_valid_reg;
    logic signed [63:0] sum_reg;
    logic               sum_ov_reg;
    logic signed [63:0] sum_next;
    logic               sum_ov_next;

    always_comb begin
        if (curve_type_reg == CURVE_RAMP) begin
            if (tag5_out.op == OP_VELOCITY) begin
                sum_x     = s64;
                sum_y     = tag5_out.r;
                sum_ov_in = tag5_out.ov[0];
            end else begin
                sum_x     = tag5_out.sp;
                sum_y     = tag5_out.m2;
                sum_ov_in = |tag5_out.ov[2:0];
            end
        end else begin
            if (tag5_out.op == OP_VELOCITY) begin
                sum_x     = s64;
                sum_y     = tag5_out.m3;
                sum_ov_in = tag5_out.ov[0] | tag5_out.ov[2] | tag5_out.ov[3];
            end else begin
                sum_x     = tag5_out.sp;
                sum_y     = rsp5.p;
                sum_ov_in = (|tag5_out.ov) | rsp5.ov;
            end
        end
        sum_full = sum_x + sum_y;
        if (sum_full > INTER_HI) begin
            sum_next    = INTER_HI;
            sum_ov_next = 1'b1;
        end else if (sum_full < INTER_LO) begin
            sum_next    = INTER_LO;
            sum_ov_next = 1'b1;
        end else begin
            sum_next    = sum_full;
            sum_ov_next = sum_ov_in;
        end
    end

    // Output clamp to 48 bits
    logic [47:0] out_value_next;
    logic        out_ov_next;
    logic [47:0] m_value_reg;
    logic        m_ov_reg;

    always_comb begin
        if (sum_reg > OUT_HI) begin
            out_value_next = OUT_HI[47:0];
            out_ov_next    = 1'b1;
        end else if (sum_reg < OUT_LO) begin
            out_value_next = OUT_LO[47:0];
            out_ov_next    = 1'b1;
        end else begin
            out_value_next = sum_reg[47:0];
            out_ov_next    = sum_ov_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else if (ce) begin
            sum_valid_reg <= rsp5.valid;
            m_valid_reg   <= sum_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sum_reg     <= sum_next;
            sum_ov_reg  <= sum_ov_next;
            m_value_reg <= out_value_next;
            m_ov_reg    <= out_ov_next;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_value_reg;
    assign m_tuser[0] = m_ov_reg;

endmodule

[rtl/core/ece_checker.sv]
// Port-level assertions for the ease curve evaluator, bound to the top level.
`timescale 1ns / 1ps

module ece_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // Reset empties the pipeline
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A held result blocks new input
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // Free output means the input side is open
    a_open_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // Held result stays put
    a_hold_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind ease_curve_evaluator ece_checker u_ece_checker (.*);

[bench/ease_curve_checker.sv]
// Checker for the ease curve evaluator: mirrors config, predicts each result, compares.
`timescale 1ns / 1ps

module ease_curve_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample_time
    input  logic [0:0]  s_tuser,   // [0] operation
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // [47:0] value
    input  logic [0:0]  m_tuser,   // [0] overflow
    output int          error_count,
    output int          outstanding
);
    import ece_pkg::*;

    localparam int FB = FRACTION_BITS_DEFAULT;

    typedef struct {
        logic [47:0] value;
        logic        overflow;
    } ease_result_t;

    ease_result_t expected_q[$];

    // Mirrored configuration
    logic        curve_type;
    logic [31:0] start_speed;
    logic [31:0] goal_speed;
    logic [31:0] ease_length;

    // Saturation seen while predicting the current item
    logic        sat_seen;

    // Exact product, floor shift, clamp to the intermediate range
    function automatic logic signed [63:0] mul_shift(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     input int sh);
        logic signed [127:0] aw;
        logic signed [127:0] bw;
        logic signed [127:0] p;
        aw = a;
        bw = b;
        p  = (aw * bw) >>> sh;
        if (p > 128'(INTER_HI)) begin
            sat_seen = 1'b1;
            return INTER_HI;
        end
        if (p < 128'(INTER_LO)) begin
            sat_seen = 1'b1;
            return INTER_LO;
        end
        return p[63:0];
    endfunction

    function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(INTER_HI)) begin
            sat_seen = 1'b1;
            return INTER_HI;
        end
        if (s < 65'(INTER_LO)) begin
            sat_seen = 1'b1;
            return INTER_LO;
        end
        return s[63:0];
    endfunction

    function automatic ease_result_t predict_ease(input logic op, input logic [31:0] t_raw);
        logic signed [63:0] one, t, len, s, delta, u, r, u2, w, e, d, res;
        logic        [63:0] len_u;
        ease_result_t out;
        sat_seen = 1'b0;
        one   = 64'sd1 <<< FB;
        t     = {32'b0, t_raw};
        len_u = (ease_length == 32'd0) ? 64'd1 : {32'b0, ease_length};
        len   = len_u;
        s     = {{32{start_speed[31]}}, start_speed};
        delta = {{32{goal_speed[31]}}, goal_speed} - s;
        u     = ({32'b0, t_raw} << FB) / len_u;
        if (curve_type != CURVE_SPLINE) begin
            r = mul_shift(delta, u, FB);
            if (op == OP_VELOCITY)
                res = add_sat(s, r);
            else
                res = add_sat(mul_shift(s, t, FB), mul_shift(r, t, FB + 1));
        end else begin
            u2 = mul_shift(u, u, FB);
            if (op == OP_VELOCITY) begin
                w   = mul_shift(u2, 3 * one - 2 * u, FB);
                res = add_sat(s, mul_shift(delta, w, FB));
            end else begin
                e   = mul_shift(u, mul_shift(u2, 2 * one - u, FB + 1), FB);
                d   = mul_shift(mul_shift(delta, e, FB), len, FB);
                res = add_sat(mul_shift(s, t, FB), d);
            end
        end
        if (res > OUT_HI) begin
            res = OUT_HI;
            sat_seen = 1'b1;
        end
        if (res < OUT_LO) begin
            res = OUT_LO;
            sat_seen = 1'b1;
        end
        out.value    = res[47:0];
        out.overflow = sat_seen;
        return out;
    endfunction

    // Track config, queue predictions, check results
    always @(posedge aclk) begin
        ease_result_t exp_item;
        int count;
        int errs;
        count = outstanding;
        errs  = error_count;
        if (!aresetn) begin
            curve_type  <= CURVE_RAMP;
            start_speed <= 32'd0;
            goal_speed  <= 32'd65536;
            ease_length <= 32'd65536;
            expected_q.delete();
            count = 0;
            errs  = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_CURVE_TYPE:  curve_type  <= cfg_wdata[0];
                    REG_START_SPEED: start_speed <= cfg_wdata;
                    REG_GOAL_SPEED:  goal_speed  <= cfg_wdata;
                    REG_EASE_LENGTH: ease_length <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_q.push_back(predict_ease(s_tuser[0], s_tdata));
                count++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result item with no prediction: value %h overflow %b",
                           m_tdata, m_tuser[0]);
                    errs++;
                end else begin
                    exp_item = expected_q.pop_front();
                    count--;
                    if (m_tdata !== exp_item.value) begin
                        $error("value: expected %h, actual %h", exp_item.value, m_tdata);
                        errs++;
                    end
                    if (m_tuser[0] !== exp_item.overflow) begin
                        $error("overflow: expected %b, actual %b",
                               exp_item.overflow, m_tuser[0]);
                        errs++;
                    end
                end
            end
        end
        outstanding <= count;
        error_count <= errs;
    end

endmodule

[bench/ease_curve_evaluator_tb.sv]
// Testbench top: drives config and time samples, stalls the output, gives the verdict.
`timescale 1ns / 1ps

module ease_curve_evaluator_tb;
    import ece_pkg::*;

    localparam int  SETTLE_CYCLES = 90;
    localparam int  LONG_HOLD     = 400;
    localparam longint CYCLE_LIMIT = 600000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = REG_CURVE_TYPE;
    logic [31:0] cfg_wdata = 32'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = 32'd0;
    logic [0:0]  s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;

    int     error_count;
    int     outstanding;
    longint cycle_count = 0;
    int     burst_left = 0;
    bit     steady_send = 1'b0;
    int     hold_seq = 0;
    logic [31:0] cur_len = 32'd65536;

    ease_curve_evaluator u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    ease_curve_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .error_count(error_count), .outstanding(outstanding)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stall modes, plus a long hold-off on request
    initial begin
        int hold_seen;
        int hold_left;
        int mode;
        int mode_left;
        hold_seen = 0;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 9) != 0);
                    default: m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
        if (idx == REG_EASE_LENGTH)
            cur_len = val;
    endtask

    // Stop offering and wait until the pipeline has emptied
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_curve(input logic curve, input logic [31:0] s, input logic [31:0] g,
                              input logic [31:0] len);
        write_reg(REG_CURVE_TYPE, {31'b0, curve});
        write_reg(REG_START_SPEED, s);
        write_reg(REG_GOAL_SPEED, g);
        write_reg(REG_EASE_LENGTH, len);
    endtask

    // Offer one item; bursts with random gaps unless sending steadily
    task automatic send_sample(input logic op, input logic [31:0] t);
        if (!steady_send && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (burst_left > 0)
            burst_left--;
    endtask

    function automatic logic [31:0] rand_time;
        logic [63:0] scaled;
        case ($urandom_range(0, 7))
            0, 1, 2, 3: begin
                scaled = (64'(cur_len) * $urandom_range(0, 300)) / 100;
                rand_time = (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
            end
            4, 5: rand_time = $urandom;
            6: rand_time = $urandom_range(0, 255);
            default: rand_time = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
        endcase
    endfunction

    function automatic logic [31:0] rand_speed;
        if ($urandom_range(0, 1))
            rand_speed = $urandom;
        else
            rand_speed = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endfunction

    task automatic random_setting;
        logic [31:0] len;
        case ($urandom_range(0, 3))
            0: len = 32'd65536;
            1: len = $urandom_range(1, 32'h0040_0000);
            2: len = $urandom_range(1, 255);
            default: len = $urandom;
        endcase
        load_curve(1'($urandom_range(0, 1)), rand_speed(), rand_speed(), len);
    endtask

    task automatic directed_samples;
        logic [31:0] times[6];
        times[0] = 32'd0;
        times[1] = 32'd1;
        times[2] = cur_len >> 1;
        times[3] = cur_len;
        times[4] = cur_len << 1;
        times[5] = 32'hFFFF_FFFF;
        foreach (times[i]) begin
            send_sample(OP_POSITION, times[i]);
            send_sample(OP_VELOCITY, times[i]);
        end
    endtask

    task automatic random_samples(input int n);
        repeat (n)
            send_sample(1'($urandom_range(0, 1)), rand_time());
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: linear ramp 0 to 1.0 over 1.0
        directed_samples();
        drain();

        // Spline with the default speeds and length
        write_reg(REG_CURVE_TYPE, {31'b0, CURVE_SPLINE});
        directed_samples();
        drain();

        // Extreme speeds over the shortest length: heavy saturation
        load_curve(CURVE_RAMP, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
        random_samples(40);
        drain();

        // Zero length counts as one raw unit
        load_curve(CURVE_SPLINE, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        random_samples(40);
        drain();

        // Longest length
        load_curve(CURVE_SPLINE, 32'hFFFF_0000, 32'h0003_0000, 32'hFFFF_FFFF);
        random_samples(40);
        drain();

        // Back-pressure: receiver holds off while items keep coming
        random_setting();
        hold_seq++;
        steady_send = 1'b1;
        random_samples(150);
        steady_send = 1'b0;
        drain();

        repeat (10) begin
            random_setting();
            random_samples(68);
            drain();
        end

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
